### sv/srr_pkg.sv
package srr_pkg;

  // Sizing of the sequence space and the receive window.
  localparam int unsigned HIGHEST_SEQ  = 7;
  localparam int unsigned WINDOW_SLOTS = 4;
  localparam int unsigned SEQ_W        = 8;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned SLOT_W       = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int unsigned CNT_W        = $clog2(WINDOW_SLOTS + 1);

  typedef logic [SEQ_W-1:0]  seq_t;
  typedef logic [SEQ_W:0]    seq_ext_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] data_t;

  localparam seq_t     SEQ_MAX   = SEQ_W'(HIGHEST_SEQ);
  localparam seq_ext_t SEQ_MOD   = (SEQ_W + 1)'(HIGHEST_SEQ + 1);
  localparam seq_ext_t WIN_SIZE  = (SEQ_W + 1)'(WINDOW_SLOTS);
  localparam slot_t    SLOT_LAST = SLOT_W'(WINDOW_SLOTS - 1);
  localparam cnt_t     CNT_FULL  = CNT_W'(WINDOW_SLOTS);

  // Result codes.
  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_NAK     = 2'd2
  } kind_e;

  // One received frame.
  typedef struct packed {
    seq_t  seq_num;
    logic  crc_ok;
    data_t payload;
  } in_t;

  // One result beat.
  typedef struct packed {
    kind_e kind;
    seq_t  number;
    data_t data;
    logic  last;
  } out_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_REPLY,
    ST_DELIVER
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load;
    logic  write_slot;
    logic  deliver;
    logic  set_nak;
    logic  clear_nak;
    logic  emit;
    kind_e emit_kind;
    logic  emit_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frame_ok;
    logic good;
    logic at_expected;
    logic head_valid;
    logic cnt_full;
    logic nak_sent;
  } dp_stat_t;

endpackage

### sv/srr_ctrl.sv
module srr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  srr_pkg::dp_stat_t stat_i,
  output srr_pkg::dp_cmd_t  cmd_o
);

  srr_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      srr_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = srr_pkg::ST_EVAL;
        end
      end
      srr_pkg::ST_EVAL: begin
        // Frames out of range, outside the window or corrupted elsewhere are dropped.
        if (!stat_i.frame_ok) begin
          state_d = srr_pkg::ST_IDLE;
        end else if (stat_i.good) begin
          cmd_o.write_slot = 1'b1;
          state_d = stat_i.at_expected ? srr_pkg::ST_DELIVER : srr_pkg::ST_REPLY;
        end else if (stat_i.at_expected) begin
          state_d = srr_pkg::ST_REPLY;
        end else begin
          state_d = srr_pkg::ST_IDLE;
        end
      end
      srr_pkg::ST_REPLY: begin
        // The first complaint about this expected number is a NAK, later ones ACKs.
        cmd_o.emit      = 1'b1;
        cmd_o.set_nak   = 1'b1;
        cmd_o.emit_kind = stat_i.nak_sent ? srr_pkg::KIND_ACK : srr_pkg::KIND_NAK;
        if (stat_i.good && stat_i.head_valid) begin
          cmd_o.emit_last = 1'b0;
          state_d         = srr_pkg::ST_DELIVER;
        end else begin
          cmd_o.emit_last = 1'b1;
          state_d         = srr_pkg::ST_IDLE;
        end
      end
      srr_pkg::ST_DELIVER: begin
        // Deliver consecutive buffered frames, then acknowledge the new head.
        cmd_o.clear_nak = 1'b1;
        cmd_o.emit      = 1'b1;
        if (stat_i.head_valid && !stat_i.cnt_full) begin
          cmd_o.deliver   = 1'b1;
          cmd_o.emit_kind = srr_pkg::KIND_DELIVER;
          cmd_o.emit_last = 1'b0;
        end else begin
          cmd_o.emit_kind = srr_pkg::KIND_ACK;
          cmd_o.emit_last = 1'b1;
          state_d         = srr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = srr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### sv/srr_dpath.sv
module srr_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srr_pkg::in_t      item_i,
  input  srr_pkg::dp_cmd_t  cmd_i,
  output srr_pkg::dp_stat_t stat_o,
  output logic              valid_o,
  output srr_pkg::out_t     result_o
);

  srr_pkg::in_t     in_q;
  srr_pkg::seq_t    exp_q, exp_d;
  srr_pkg::slot_t   head_q, head_d;
  srr_pkg::cnt_t    cnt_q, cnt_d;
  logic             nak_q, nak_d;
  logic             valid_slot_q [srr_pkg::WINDOW_SLOTS];
  srr_pkg::data_t   payload_q [srr_pkg::WINDOW_SLOTS];
  srr_pkg::out_t    res_q, res_d;
  logic             res_valid_q;

  srr_pkg::seq_ext_t seq_ext, exp_ext, offset;
  logic [srr_pkg::SLOT_W:0] slot_sum;
  srr_pkg::slot_t   slot_idx;
  logic             in_range, in_window;

  // Offset of the frame from the expected number, modulo the sequence space.
  always_comb begin
    seq_ext = {1'b0, in_q.seq_num};
    exp_ext = {1'b0, exp_q};
    if (in_q.seq_num >= exp_q) begin
      offset = seq_ext - exp_ext;
    end else begin
      offset = seq_ext + srr_pkg::SEQ_MOD - exp_ext;
    end
    in_range  = in_q.seq_num <= srr_pkg::SEQ_MAX;
    in_window = offset < srr_pkg::WIN_SIZE;
    slot_sum  = {1'b0, head_q} + {1'b0, offset[srr_pkg::SLOT_W-1:0]};
    if (slot_sum >= (srr_pkg::SLOT_W + 1)'(srr_pkg::WINDOW_SLOTS)) begin
      slot_idx = srr_pkg::SLOT_W'(slot_sum - (srr_pkg::SLOT_W + 1)'(srr_pkg::WINDOW_SLOTS));
    end else begin
      slot_idx = slot_sum[srr_pkg::SLOT_W-1:0];
    end
  end

  // Status towards the controller.
  always_comb begin
    stat_o.frame_ok    = in_range && in_window;
    stat_o.good        = in_q.crc_ok;
    stat_o.at_expected = in_q.seq_num == exp_q;
    stat_o.head_valid  = valid_slot_q[head_q];
    stat_o.cnt_full    = cnt_q == srr_pkg::CNT_FULL;
    stat_o.nak_sent    = nak_q;
  end

  // Window pointer, counter and flag updates.
  always_comb begin
    exp_d  = exp_q;
    head_d = head_q;
    cnt_d  = cnt_q;
    nak_d  = nak_q;
    if (cmd_i.load) begin
      cnt_d = '0;
    end
    if (cmd_i.deliver) begin
      head_d = (head_q == srr_pkg::SLOT_LAST) ? '0 : head_q + srr_pkg::slot_t'(1);
      exp_d  = (exp_q == srr_pkg::SEQ_MAX) ? '0 : exp_q + srr_pkg::seq_t'(1);
      cnt_d  = cnt_q + srr_pkg::cnt_t'(1);
    end
    if (cmd_i.set_nak) begin
      nak_d = 1'b1;
    end
    if (cmd_i.clear_nak) begin
      nak_d = 1'b0;
    end
  end

  // Next result beat.
  always_comb begin
    res_d.kind = cmd_i.emit_kind;
    res_d.last = cmd_i.emit_last;
    res_d.number = exp_q;
    if (cmd_i.emit_kind == srr_pkg::KIND_DELIVER) begin
      res_d.data = payload_q[head_q];
    end else begin
      res_d.data = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q       <= '0;
      head_q      <= '0;
      cnt_q       <= '0;
      nak_q       <= 1'b0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < srr_pkg::WINDOW_SLOTS; i++) begin
        valid_slot_q[i] <= 1'b0;
      end
    end else begin
      exp_q       <= exp_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      nak_q       <= nak_d;
      res_valid_q <= cmd_i.emit;
      if (cmd_i.write_slot) begin
        valid_slot_q[slot_idx] <= 1'b1;
      end
      if (cmd_i.deliver) begin
        valid_slot_q[head_q] <= 1'b0;
      end
    end
  end

  // Payload registers: frame capture, slot store and result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= item_i;
    end
    if (cmd_i.write_slot) begin
      payload_q[slot_idx] <= in_q.payload;
    end
    if (cmd_i.emit) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = res_valid_q;
  assign result_o = res_q;

endmodule

### sv/selective_repeat_receiver.sv
// Selective-repeat ARQ receiver.
// Input channel: a frame (sequence number, CRC flag, payload word) on item_i is
// taken at a rising edge where start is high and busy is low. busy stays high
// until the controller has issued the last result beat of that frame, so the
// next frame can be taken at the edge that ends the cycle in which that beat is out.
// Output channel: each result beat is on result_o for exactly one cycle, marked
// by valid_o; the receiver must take it then and cannot stall the block.
// A beat is a NAK or ACK for the expected number, a delivered payload, or the
// closing ACK after deliveries; last marks the final beat of a frame.
// A taken frame is registered and judged in EVAL; REPLY or DELIVER then emits
// its beats through the result register, one beat per cycle while DELIVER
// steps the window head. A frame has 0 to WINDOW_SLOTS + 1 beats. A dropped
// frame goes from EVAL back to IDLE with no beat.
// Reset clears the expected number, the window head, all slot valid bits and
// the NAK flag; slot payloads need no clearing.
module selective_repeat_receiver (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  srr_pkg::in_t   item_i,
  output logic           valid_o,
  output srr_pkg::out_t  result_o
);

  srr_pkg::dp_cmd_t  cmd;
  srr_pkg::dp_stat_t stat;

  srr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  srr_dpath u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

endmodule

### tb/tb_selective_repeat_receiver.sv
`timescale 1ns / 1ps

module tb_selective_repeat_receiver;

  localparam int unsigned SEQ_SPACE    = srr_pkg::HIGHEST_SEQ + 1;
  localparam int unsigned MAX_BEATS    = srr_pkg::WINDOW_SLOTS + 2;
  localparam int unsigned RANDOM_ITEMS = 370;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 2 * (MAX_BEATS + 4);

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           start;
  logic           busy;
  srr_pkg::in_t   item_i;
  logic           valid_o;
  srr_pkg::out_t  result_o;

  // Frames waiting to be offered, and result beats still owed by the block.
  srr_pkg::in_t   pending_frames[$];
  srr_pkg::out_t  expected_beats[$];

  // Shadow copy of the receiver window.
  srr_pkg::seq_t  next_seq;
  int unsigned    head_pos;
  logic           slot_full[srr_pkg::WINDOW_SLOTS];
  srr_pkg::data_t slot_word[srr_pkg::WINDOW_SLOTS];
  logic           nak_out;

  bit          frame_taken;
  int unsigned frames_sent;
  int unsigned total_frames;
  int unsigned idle_pct;
  int unsigned cycles;
  int unsigned errors;

  selective_repeat_receiver DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  always #1 clk_i = ~clk_i;

  // Works out the beats that one accepted frame produces and updates the window copy.
  task automatic predict_frame(input srr_pkg::in_t f);
    srr_pkg::out_t beats[MAX_BEATS];
    int unsigned   nb;
    int unsigned   ofs;
    int unsigned   s;
    int unsigned   guard;
    nb = 0;
    if (f.seq_num > srr_pkg::SEQ_MAX) return;
    ofs = (int'(f.seq_num) + SEQ_SPACE - int'(next_seq)) % SEQ_SPACE;
    if (ofs >= srr_pkg::WINDOW_SLOTS) return;
    if (f.crc_ok) begin
      s = (head_pos + ofs) % srr_pkg::WINDOW_SLOTS;
      slot_word[s] = f.payload;
      slot_full[s] = 1'b1;
      if (f.seq_num != next_seq) begin
        beats[nb] = '{kind: nak_out ? srr_pkg::KIND_ACK : srr_pkg::KIND_NAK,
                      number: next_seq, data: '0, last: 1'b0};
        nak_out = 1'b1;
        nb++;
      end
      // Hand over every consecutive buffered payload, then acknowledge.
      if (slot_full[head_pos]) begin
        nak_out = 1'b0;
        guard = 0;
        while (guard < srr_pkg::WINDOW_SLOTS && slot_full[head_pos]) begin
          beats[nb] = '{kind: srr_pkg::KIND_DELIVER, number: next_seq,
                        data: slot_word[head_pos], last: 1'b0};
          nb++;
          slot_full[head_pos] = 1'b0;
          head_pos = (head_pos + 1) % srr_pkg::WINDOW_SLOTS;
          next_seq = srr_pkg::seq_t'((int'(next_seq) + 1) % SEQ_SPACE);
          guard++;
        end
        beats[nb] = '{kind: srr_pkg::KIND_ACK, number: next_seq, data: '0, last: 1'b0};
        nb++;
      end
    end else if (f.seq_num == next_seq) begin
      beats[nb] = '{kind: nak_out ? srr_pkg::KIND_ACK : srr_pkg::KIND_NAK,
                    number: next_seq, data: '0, last: 1'b0};
      nak_out = 1'b1;
      nb++;
    end
    if (nb > 0) beats[nb-1].last = 1'b1;
    for (int i = 0; i < nb; i++) expected_beats.push_back(beats[i]);
  endtask

  function automatic srr_pkg::in_t frame(input int unsigned seq, input bit good,
                                         input srr_pkg::data_t word);
    srr_pkg::in_t f;
    f.seq_num = srr_pkg::seq_t'(seq);
    f.crc_ok  = good;
    f.payload = word;
    return f;
  endfunction

  // Acceptance and result checking at the rising edge.
  always @(posedge clk_i) begin
    srr_pkg::out_t got;
    srr_pkg::out_t want;
    if (valid_o) begin
      got = result_o;
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: kind %0d number %0d data %h last %0d",
               got.kind, got.number, got.data, got.last);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        if (got.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, got.kind);
          errors++;
        end
        if (got.number !== want.number) begin
          $error("number: expected %0d, actual %0d", want.number, got.number);
          errors++;
        end
        if (got.data !== want.data) begin
          $error("data: expected %h, actual %h", want.data, got.data);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, got.last);
          errors++;
        end
      end
    end
    if (rst_ni && start && !busy) begin
      predict_frame(item_i);
      frame_taken = 1'b1;
    end
  end

  // Frame driver: a new frame goes out once the previous one has been taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!start || frame_taken)) begin
      frame_taken = 1'b0;
      if (frames_sent < total_frames / 3) idle_pct = 11;
      else if (frames_sent < 2 * total_frames / 3) idle_pct = 68;
      else idle_pct = 0;
      if (pending_frames.size() != 0 && $urandom_range(99) >= idle_pct) begin
        item_i <= pending_frames.pop_front();
        start  <= 1'b1;
        frames_sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("selective_repeat_receiver: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned  counted;
    int unsigned  gen_base;
    int unsigned  len;
    int unsigned  seq;
    int unsigned  tmp;
    int unsigned  j;
    int unsigned  ord[srr_pkg::WINDOW_SLOTS];
    srr_pkg::in_t f;

    rst_ni       = 1'b0;
    start        = 1'b0;
    item_i       = '0;
    frame_taken  = 1'b0;
    frames_sent  = 0;
    cycles       = 0;
    errors       = 0;
    next_seq     = '0;
    head_pos     = 0;
    nak_out      = 1'b0;
    for (int i = 0; i < srr_pkg::WINDOW_SLOTS; i++) begin
      slot_full[i] = 1'b0;
      slot_word[i] = '0;
    end

    // Directed part: dropped frames first, then NAK and ACK rules, a full window and wrap.
    pending_frames.push_back(frame(8, 1, 32'h1234_5678));    // out of range
    pending_frames.push_back(frame(255, 1, 32'hFFFF_FFFF));  // out of range, all ones
    pending_frames.push_back(frame(1, 0, 32'h0));            // bad CRC away from expected
    pending_frames.push_back(frame(5, 1, 32'hA5A5_A5A5));    // outside the window
    pending_frames.push_back(frame(2, 1, 32'hFFFF_FFFF));    // out of order: NAK
    pending_frames.push_back(frame(0, 0, 32'h0));            // bad at expected: ACK now
    pending_frames.push_back(frame(3, 1, 32'h5555_5555));
    pending_frames.push_back(frame(1, 1, 32'hDEAD_BEEF));
    pending_frames.push_back(frame(1, 1, 32'h0000_0000));    // overwrite a full slot
    pending_frames.push_back(frame(0, 1, 32'hAAAA_AAAA));    // whole window delivered
    pending_frames.push_back(frame(4, 0, 32'hFFFF_FFFF));    // bad at expected: NAK
    pending_frames.push_back(frame(4, 0, 32'h0));            // and then ACK
    pending_frames.push_back(frame(4, 1, 32'h0));
    pending_frames.push_back(frame(7, 1, 32'h8000_0001));
    pending_frames.push_back(frame(6, 1, 32'h7FFF_FFFE));
    pending_frames.push_back(frame(0, 1, 32'h1111_1111));    // inside the window after wrap
    pending_frames.push_back(frame(5, 1, 32'h0F0F_F0F0));    // delivers across the wrap
    pending_frames.push_back(frame(0, 1, 32'hFFFF_FFFF));
    pending_frames.push_back(frame(128, 0, 32'h0));
    pending_frames.push_back(frame(127, 1, 32'h0));

    // Random part: mostly shuffled runs of the window, with corrupt frames and noise mixed in.
    counted  = 0;
    gen_base = 1;
    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 75) begin
        len = $urandom_range(srr_pkg::WINDOW_SLOTS, 1);
        for (int i = 0; i < len; i++) ord[i] = i;
        for (int i = len - 1; i > 0; i--) begin
          j = $urandom_range(i);
          tmp = ord[i];
          ord[i] = ord[j];
          ord[j] = tmp;
        end
        for (int i = 0; i < len; i++) begin
          f = frame((gen_base + ord[i]) % SEQ_SPACE, $urandom_range(9) != 0, $urandom);
          pending_frames.push_back(f);
          counted++;
          if ($urandom_range(9) == 0) begin
            pending_frames.push_back(f);
            counted++;
          end
        end
        gen_base = (gen_base + len) % SEQ_SPACE;
      end else begin
        if ($urandom_range(9) < 6) seq = $urandom_range(srr_pkg::HIGHEST_SEQ);
        else seq = $urandom_range(255);
        pending_frames.push_back(frame(seq, $urandom_range(1), $urandom));
        if (seq <= srr_pkg::HIGHEST_SEQ) counted++;
      end
    end
    total_frames = pending_frames.size();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every frame taken, the block idle and every beat seen.
    while (pending_frames.size() != 0 || start || busy || expected_beats.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_beats.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_beats.size());
      errors++;
    end
    if (errors == 0) begin
      $display("selective_repeat_receiver: match");
    end else begin
      $display("selective_repeat_receiver: mismatch");
    end
    $finish;
  end

endmodule
